// ===== rtl/core/slcp_pkg.sv =====
// Shared types and constants of the servo line command parser.
package slcp_pkg;

    // Character codes the parser looks for.
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_J     = 8'h4A;
    localparam logic [7:0] CHAR_G     = 8'h47;
    localparam logic [7:0] CHAR_R     = 8'h52;

    // Joints that own an id register; the gripper register follows them.
    localparam int unsigned JOINT_REGS  = 7;
    localparam logic [2:0]  CFG_GRIPPER = 3'd7;

    // Field widths.
    localparam int unsigned ID_W      = 4;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned POS_ACC_W = POS_W + 1;
    localparam int unsigned RESULT_W  = 24;

    localparam logic [ID_W-1:0] ID_SAT = '1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_RESET    = 3'd0,
        ST_JOINT    = 3'd1,
        ST_GRIPPER  = 3'd2,
        ST_BAD_TYPE = 3'd3,
        ST_BAD_ID   = 3'd4,
        ST_BAD_POS  = 3'd5,
        ST_ID_RANGE = 3'd6,
        ST_FORMAT   = 3'd7
    } status_t;

    // Where in the line the parser stands.
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ID   = 2'd1,
        PH_POS  = 2'd2
    } phase_t;

    // Running state of the current line.
    typedef struct packed {
        phase_t               phase;
        logic [7:0]           type_char;
        logic [1:0]           char_count;
        logic [ID_W-1:0]      id_value;
        logic                 id_bad;
        logic [POS_ACC_W-1:0] pos_value;
        logic                 pos_bad;
        logic                 pos_seen;
        logic                 space_pending;
    } line_state_t;

    // One result, packed as it leaves on the output stream.
    typedef struct packed {
        logic [POS_W-1:0] position;
        logic [2:0]       joint_index;
        logic [7:0]       servo_id;
        status_t          status;
    } result_t;

endpackage

// ===== rtl/core/slcp_line_state.sv =====
// Per-character state update of the line being parsed.
module slcp_line_state #(
    parameter int unsigned POSITION_MAX = 1000
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_take,
    input  logic [7:0]           rx_byte,
    output slcp_pkg::line_state_t line_state
);
    import slcp_pkg::*;

    localparam logic [POS_ACC_W-1:0] POS_SAT = POS_ACC_W'(POSITION_MAX + 1);

    line_state_t       state_reg;
    line_state_t       state_next;
    logic              is_ws;
    logic              is_digit;
    logic [3:0]        digit;
    logic [7:0]        id_ext;
    logic [7:0]        id_mul;
    logic [13:0]       pos_ext;
    logic [13:0]       pos_mul;

    function automatic logic [1:0] sat_inc(input logic [1:0] v);
        sat_inc = (v == 2'd3) ? v : v + 2'd1;
    endfunction

    assign line_state = state_reg;

    // Character classes and the decimal accumulate for both number parts.
    always_comb
    begin
        is_ws    = (rx_byte == CHAR_SPACE) || (rx_byte inside {[8'h09:8'h0D]});
        is_digit = (rx_byte inside {[8'h30:8'h39]});
        digit    = rx_byte[3:0];
        id_ext   = {4'b0000, state_reg.id_value};
        id_mul   = (id_ext << 3) + (id_ext << 1) + {4'b0000, digit};
        pos_ext  = {3'b000, state_reg.pos_value};
        pos_mul  = (pos_ext << 3) + (pos_ext << 1) + {10'd0, digit};
    end

    // Next line state.
    always_comb
    begin
        state_next = state_reg;
        if (byte_take)
        begin
            if (rx_byte == CHAR_LF)
            begin
                state_next = '0;
            end
            else if (is_ws)
            begin
                if (state_reg.phase != PH_IDLE)
                begin
                    state_next.space_pending = 1'b1;
                end
            end
            else if (state_reg.phase == PH_IDLE)
            begin
                state_next.type_char  = rx_byte;
                state_next.char_count = 2'd1;
                state_next.phase      = (rx_byte == CHAR_COLON) ? PH_POS : PH_ID;
            end
            else
            begin
                // Whitespace held back turns out to sit inside the line.
                if (state_reg.space_pending)
                begin
                    state_next.char_count    = sat_inc(state_reg.char_count);
                    state_next.space_pending = 1'b0;
                    if (state_reg.phase == PH_ID)
                    begin
                        state_next.id_bad = 1'b1;
                    end
                    else if (state_reg.phase == PH_POS)
                    begin
                        state_next.pos_bad = 1'b1;
                    end
                end
                state_next.char_count = sat_inc(state_next.char_count);

                case (state_reg.phase)
                    PH_ID:
                    begin
                        if (rx_byte == CHAR_COLON)
                        begin
                            state_next.phase = PH_POS;
                        end
                        else if (is_digit)
                        begin
                            state_next.id_value = (id_mul > {4'b0000, ID_SAT}) ?
                                                  ID_SAT : id_mul[ID_W-1:0];
                        end
                        else
                        begin
                            state_next.id_bad = 1'b1;
                        end
                    end
                    PH_POS:
                    begin
                        state_next.pos_seen = 1'b1;
                        if (is_digit)
                        begin
                            state_next.pos_value = (pos_mul > {3'b000, POS_SAT}) ?
                                                   POS_SAT : pos_mul[POS_ACC_W-1:0];
                        end
                        else
                        begin
                            state_next.pos_bad = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next.pos_seen = state_reg.pos_seen;
                    end
                endcase
            end
        end
    end

    // Line state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/slcp_decode.sv =====
// Decision of the status, servo id and position at the end of a line.
module slcp_decode #(
    parameter int unsigned NUM_JOINTS   = 7,
    parameter int unsigned POSITION_MAX = 1000
) (
    input  slcp_pkg::line_state_t                      line_state,
    input  logic [slcp_pkg::JOINT_REGS-1:0][7:0]       joint_ids,
    input  logic [7:0]                                 gripper_id,
    output slcp_pkg::result_t                          result
);
    import slcp_pkg::*;

    localparam logic [POS_ACC_W-1:0] POS_LIMIT = POS_ACC_W'(POSITION_MAX);
    localparam logic [ID_W-1:0]      JOINT_LIM = ID_W'(NUM_JOINTS);
    localparam logic [ID_W-1:0]      REGS_LIM  = ID_W'(JOINT_REGS);

    logic [POS_W-1:0] pos_clamped;
    logic [7:0]       joint_sid;
    logic             type_j;
    logic             type_g;

    // Clamped position and the id register of the addressed joint.
    always_comb
    begin
        pos_clamped = (line_state.pos_value > POS_LIMIT) ?
                      POS_W'(POSITION_MAX) : line_state.pos_value[POS_W-1:0];
        joint_sid   = (line_state.id_value < REGS_LIM) ?
                      joint_ids[line_state.id_value[2:0]] : 8'd0;
        type_j      = (line_state.type_char == CHAR_J);
        type_g      = (line_state.type_char == CHAR_G);
    end

    // Checks in priority order.
    always_comb
    begin
        result = '0;
        if (line_state.type_char == CHAR_R && line_state.char_count == 2'd1)
        begin
            result.status = ST_RESET;
        end
        else if (line_state.phase != PH_POS || !line_state.pos_seen)
        begin
            result.status = ST_FORMAT;
        end
        else if (!type_j && !type_g)
        begin
            result.status = ST_BAD_TYPE;
        end
        else if (line_state.id_bad)
        begin
            result.status = ST_BAD_ID;
        end
        else if (line_state.pos_bad)
        begin
            result.status = ST_BAD_POS;
        end
        else if (type_j && line_state.id_value < JOINT_LIM)
        begin
            result.status      = ST_JOINT;
            result.joint_index = line_state.id_value[2:0];
            result.servo_id    = joint_sid;
            result.position    = pos_clamped;
        end
        else if (type_g)
        begin
            result.status   = ST_GRIPPER;
            result.servo_id = gripper_id;
            result.position = pos_clamped;
        end
        else
        begin
            result.status = ST_ID_RANGE;
        end
    end

endmodule

// ===== rtl/core/servo_line_command_parser.sv =====
// Top level of the servo line command parser: id registers, parser and result register.
//
//  channel  | signals                          | payload
//  ---------+----------------------------------+------------------------------------------
//  s (in)   | s_tvalid, s_tready, s_tdata[7:0] | rx_byte
//  m (out)  | m_tvalid, m_tready, m_tdata[23:0]| status, servo_id, joint_index, position
//  cfg      | cfg_wr_en, cfg_addr, cfg_wdata   | joint0..6 ids, gripper id
//
// One byte is taken per cycle while s_tready is high; a result appears the cycle after its newline.
// The single result register sets the pace: a byte is refused only while a
// result waits and the output is stalled.
// Reset puts the id registers to 1..8 and clears the line state.
module servo_line_command_parser #(
    parameter int unsigned NUM_JOINTS   = 7,
    parameter int unsigned POSITION_MAX = 1000
) (
    input  logic        clk,
    input  logic        rst_n,
    // Received character: rx_byte[7:0].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,
    // Result: status[2:0], servo_id[10:3], joint_index[13:11], position[23:14].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);
    import slcp_pkg::*;

    logic [JOINT_REGS-1:0][7:0] joint_id_reg;
    logic [7:0]                 gripper_id_reg;
    line_state_t                line_state;
    result_t                    result;
    result_t                    result_reg;
    logic                       m_valid_reg;
    logic                       byte_take;
    logic                       emit;

    assign s_tready  = !m_valid_reg || m_tready;
    assign byte_take = s_tvalid && s_tready;
    assign emit      = byte_take && (s_tdata == CHAR_LF) && (line_state.phase != PH_IDLE);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {result_reg.position, result_reg.joint_index,
                        result_reg.servo_id, result_reg.status};

    // Servo id registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < JOINT_REGS; i++)
            begin
                joint_id_reg[i] <= 8'(i + 1);
            end
            gripper_id_reg <= 8'd8;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_addr == CFG_GRIPPER)
            begin
                gripper_id_reg <= cfg_wdata;
            end
            else
            begin
                joint_id_reg[cfg_addr] <= cfg_wdata;
            end
        end
    end

    slcp_line_state #(
        .POSITION_MAX (POSITION_MAX)
    ) u_line_state (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_take  (byte_take),
        .rx_byte    (s_tdata),
        .line_state (line_state)
    );

    slcp_decode #(
        .NUM_JOINTS   (NUM_JOINTS),
        .POSITION_MAX (POSITION_MAX)
    ) u_decode (
        .line_state (line_state),
        .joint_ids  (joint_id_reg),
        .gripper_id (gripper_id_reg),
        .result     (result)
    );

    // Result register: loaded at a newline that ends a non-empty line, emptied when the request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            result_reg <= result;
        end
    end

endmodule

// ===== rtl/core/slcp_checker.sv =====
// Port-level checks of the servo line command parser, bound to the top level.
module slcp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);
    import slcp_pkg::*;

    // Input is only held off by a waiting, stalled result.
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input refused while the result register is free");

    // A stalled result keeps its data.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or vanished");

    // Only a newline can raise a fresh result.
    a_no_result_without_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tdata != CHAR_LF) |=> !m_tvalid)
        else $error("result appeared without a newline");

    // Commands that are not moves carry no id, joint or position.
    a_non_move_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != ST_JOINT && m_tdata[2:0] != ST_GRIPPER)
        |-> (m_tdata[23:3] == 21'd0))
        else $error("non-move result carries payload");

    // Only a joint move names a joint.
    a_joint_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[2:0] != ST_JOINT) |-> (m_tdata[13:11] == 3'd0))
        else $error("joint index set on a result that is not a joint move");

endmodule

bind servo_line_command_parser slcp_checker u_slcp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb.sv =====
// Self-checking testbench of the servo line command parser: directed and random command lines.
`timescale 1ns / 1ps

module tb;
    import slcp_pkg::*;

    localparam int unsigned JOINT_COUNT = 7;
    localparam int unsigned POS_LIMIT   = 1000;
    localparam int unsigned RUN_LIMIT   = 400000;
    localparam int unsigned PHASE_CHARS = 260;

    // Characters the parser treats specially beyond those of the package.
    localparam logic [7:0] CHAR_TAB  = 8'h09;
    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_FF   = 8'h0C;
    localparam logic [7:0] CHAR_CR   = 8'h0D;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_9    = 8'h39;

    // How the servo id map is filled for a phase.
    typedef enum logic [1:0] {
        MAP_LOW,
        MAP_HIGH,
        MAP_RANDOM
    } map_fill_t;

    // One directed command line and, where obvious, the reply it must give.
    typedef struct {
        string      text;
        bit         has_head;
        logic [7:0] head;
        bit         typed;
        result_t    want;
    } line_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;

    // Predictor copy of the id registers and of the running line.
    logic [7:0]           servo_map [0:7];
    phase_t               ln_phase;
    logic [7:0]           ln_lead;
    logic [1:0]           ln_count;
    logic [ID_W-1:0]      ln_id;
    logic                 ln_id_bad;
    logic [POS_ACC_W-1:0] ln_pos;
    logic                 ln_pos_bad;
    logic                 ln_pos_seen;
    logic                 ln_gap;

    result_t    due_replies [$];
    logic [7:0] line_buf [$];
    line_row_t  dir_rows [$];
    bit         idle_on = 1'b1;
    int         stall_left = 0;
    int         cycles = 0;
    int         mismatches = 0;
    int         chars_sent = 0;
    int         replies_seen = 0;
    int         map_settings = 0;
    int         status_hits [0:7];

    servo_line_command_parser #(
        .NUM_JOINTS   (JOINT_COUNT),
        .POSITION_MAX (POS_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock with an 8 ns period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit in case the block stops answering.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT)
        begin
            $display("servo_line_command_parser regression: fail");
            $finish;
        end
    end

    function automatic result_t make_reply(status_t st, logic [7:0] sid, logic [2:0] jx,
                                           logic [POS_W-1:0] pos);
        result_t r;
        r.status      = st;
        r.servo_id    = sid;
        r.joint_index = jx;
        r.position    = pos;
        return r;
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CHAR_0 && c <= CHAR_9;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_VT;
            3: return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    task automatic clear_line_state();
        ln_phase    = PH_IDLE;
        ln_lead     = '0;
        ln_count    = '0;
        ln_id       = '0;
        ln_id_bad   = 1'b0;
        ln_pos      = '0;
        ln_pos_bad  = 1'b0;
        ln_pos_seen = 1'b0;
        ln_gap      = 1'b0;
    endtask

    task automatic bump_count();
        if (ln_count != 2'd3)
            ln_count = ln_count + 2'd1;
    endtask

    // Feeds one character to the predictor; at a newline ending a non-empty
    // line it gives the reply the parser owes.
    task automatic interpret_char(input logic [7:0] c, output bit fired, output result_t r);
        int               v;
        logic [POS_W-1:0] pos_clamped;
        logic [7:0]       joint_sid;
        fired = 1'b0;
        r     = '0;
        if (c == CHAR_LF)
        begin
            if (ln_phase != PH_IDLE)
            begin
                fired = 1'b1;
                pos_clamped = (ln_pos > POS_LIMIT) ? POS_W'(POS_LIMIT) : ln_pos[POS_W-1:0];
                // A joint without its own register answers servo id zero.
                joint_sid = (ln_id < JOINT_REGS) ? servo_map[ln_id[2:0]] : 8'd0;
                if (ln_lead == CHAR_R && ln_count == 2'd1)
                    r.status = ST_RESET;
                else if (ln_phase != PH_POS || !ln_pos_seen)
                    r.status = ST_FORMAT;
                else if (ln_lead != CHAR_J && ln_lead != CHAR_G)
                    r.status = ST_BAD_TYPE;
                else if (ln_id_bad)
                    r.status = ST_BAD_ID;
                else if (ln_pos_bad)
                    r.status = ST_BAD_POS;
                else if (ln_lead == CHAR_J && ln_id < JOINT_COUNT)
                    r = make_reply(ST_JOINT, joint_sid, ln_id[2:0], pos_clamped);
                else if (ln_lead == CHAR_G)
                    r = make_reply(ST_GRIPPER, servo_map[CFG_GRIPPER], '0, pos_clamped);
                else
                    r.status = ST_ID_RANGE;
            end
            clear_line_state();
        end
        else if (is_blank(c))
        begin
            // Blanks only count once something follows them in the line.
            if (ln_phase != PH_IDLE)
                ln_gap = 1'b1;
        end
        else if (ln_phase == PH_IDLE)
        begin
            ln_lead  = c;
            ln_count = 2'd1;
            ln_phase = (c == CHAR_COLON) ? PH_POS : PH_ID;
        end
        else
        begin
            if (ln_gap)
            begin
                bump_count();
                if (ln_phase == PH_ID)
                    ln_id_bad = 1'b1;
                else
                    ln_pos_bad = 1'b1;
                ln_gap = 1'b0;
            end
            bump_count();
            if (ln_phase == PH_ID)
            begin
                if (c == CHAR_COLON)
                    ln_phase = PH_POS;
                else if (is_digit(c))
                begin
                    v = int'(ln_id) * 10 + int'(c - CHAR_0);
                    ln_id = (v > 15) ? ID_SAT : ID_W'(v);
                end
                else
                    ln_id_bad = 1'b1;
            end
            else
            begin
                ln_pos_seen = 1'b1;
                if (is_digit(c))
                begin
                    v = int'(ln_pos) * 10 + int'(c - CHAR_0);
                    ln_pos = (v > POS_LIMIT + 1) ? POS_ACC_W'(POS_LIMIT + 1) : POS_ACC_W'(v);
                end
                else
                    ln_pos_bad = 1'b1;
            end
        end
    endtask

    // Sends one character, waits for its request to be taken and records the
    // reply it causes, if any. A typed reply replaces the predicted one.
    task automatic send_char(input logic [7:0] c, input bit typed, input result_t want);
        bit      fired;
        result_t r;
        if (idle_on && $urandom_range(0, 6) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        do
            @(posedge clk);
        while (!s_tready);
        chars_sent++;
        interpret_char(c, fired, r);
        if (fired)
            due_replies.push_back(typed ? want : r);
    endtask

    // Stops sending and waits until every owed reply has come and the
    // parser has settled.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all eight id registers, one per cycle.
    task automatic program_servo_map(input map_fill_t fill);
        logic [7:0] val;
        for (int i = 0; i < 8; i++)
        begin
            case (fill)
                MAP_LOW:  val = 8'd0;
                MAP_HIGH: val = 8'd253;
                default:  val = 8'($urandom_range(0, 253));
            endcase
            cfg_wr_en    <= 1'b1;
            cfg_addr     <= 3'(i);
            cfg_wdata    <= val;
            servo_map[i] = val;
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        map_settings++;
    endtask

    // Builds one random command line into line_buf: mostly well-formed
    // moves, then lone resets, damaged moves, noise and blank lines.
    task automatic gen_line();
        int n;
        int kind;
        int at;
        logic [7:0] odd;
        line_buf.delete();
        kind = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) line_buf.push_back(pick_blank());
        if (kind < 62 || (kind >= 72 && kind < 86))
        begin
            line_buf.push_back(($urandom_range(0, 2) != 0) ? CHAR_J : CHAR_G);
            n = ($urandom_range(0, 9) < 8) ? 1 : $urandom_range(0, 4);
            repeat (n) line_buf.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
            line_buf.push_back(CHAR_COLON);
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(0, 5);
            repeat (n) line_buf.push_back(8'(CHAR_0 + $urandom_range(0, 9)));
        end
        else if (kind < 72)
            line_buf.push_back(CHAR_R);
        else if (kind < 94)
            repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(0, 255)));

        // Damage a move: a stray byte, blank or colon replaces or joins it.
        if (kind >= 72 && kind < 86)
        begin
            case ($urandom_range(0, 2))
                0: odd = 8'($urandom_range(0, 255));
                1: odd = pick_blank();
                default: odd = CHAR_COLON;
            endcase
            at = $urandom_range(0, line_buf.size() - 1);
            if ($urandom_range(0, 1) == 0)
                line_buf[at] = odd;
            else
                line_buf.insert(at, odd);
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) line_buf.push_back(pick_blank());
        line_buf.push_back(CHAR_LF);
    endtask

    // Output side: random stalls and a check of every reply against the
    // oldest one owed.
    always @(posedge clk)
    begin : reply_check
        result_t got;
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            replies_seen++;
            status_hits[got.status]++;
            if (due_replies.size() == 0)
            begin
                $error("reply %h with no command line pending", m_tdata);
                mismatches++;
            end
            else
            begin
                want = due_replies.pop_front();
                if (got.status != want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, got.status);
                    mismatches++;
                end
                if (got.servo_id != want.servo_id)
                begin
                    $error("servo_id: expected %0d, actual %0d", want.servo_id, got.servo_id);
                    mismatches++;
                end
                if (got.joint_index != want.joint_index)
                begin
                    $error("joint_index: expected %0d, actual %0d",
                           want.joint_index, got.joint_index);
                    mismatches++;
                end
                if (got.position != want.position)
                begin
                    $error("position: expected %0d, actual %0d", want.position, got.position);
                    mismatches++;
                end
            end
        end
        if (stall_left > 0)
            stall_left--;
        else if (idle_on && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 11);
        m_tready <= (stall_left == 0);
    end

    // Stimulus: reset, directed lines with the reset id map, then random
    // phases over several id maps, the last one without idling.
    initial
    begin
        map_fill_t fill;
        int        phase_chars;
        line_row_t row;

        for (int i = 0; i < 8; i++)
        begin
            servo_map[i]   = 8'(i + 1);
            status_hits[i] = 0;
        end
        clear_line_state();

        dir_rows.push_back('{"R\n", 0, 8'h00, 1, make_reply(ST_RESET, 0, 0, 0)});
        dir_rows.push_back('{"J0:1000\n", 0, 8'h00, 1, make_reply(ST_JOINT, 1, 0, 1000)});
        dir_rows.push_back('{"J6:99999\n", 0, 8'h00, 1, make_reply(ST_JOINT, 7, 6, 1000)});
        dir_rows.push_back('{"G5:0\n", 0, 8'h00, 1, make_reply(ST_GRIPPER, 8, 0, 0)});
        dir_rows.push_back('{"J0:0\n", 0, 8'h00, 1, make_reply(ST_JOINT, 1, 0, 0)});
        dir_rows.push_back('{"\n", 0, 8'h00, 0, '0});
        dir_rows.push_back('{" \011\015\n", 0, 8'h00, 0, '0});
        dir_rows.push_back('{"  J3:512 \014\n", 0, 8'h00, 0, '0});
        dir_rows.push_back('{"X1:2\n", 0, 8'h00, 1, make_reply(ST_BAD_TYPE, 0, 0, 0)});
        dir_rows.push_back('{":5\n", 0, 8'h00, 1, make_reply(ST_BAD_TYPE, 0, 0, 0)});
        dir_rows.push_back('{":5\n", 1, 8'h00, 1, make_reply(ST_BAD_TYPE, 0, 0, 0)});
        dir_rows.push_back('{"J1a:2\n", 0, 8'h00, 1, make_reply(ST_BAD_ID, 0, 0, 0)});
        dir_rows.push_back('{"J 1:5\n", 0, 8'h00, 1, make_reply(ST_BAD_ID, 0, 0, 0)});
        dir_rows.push_back('{"G\377:5\n", 0, 8'h00, 1, make_reply(ST_BAD_ID, 0, 0, 0)});
        dir_rows.push_back('{"J1:2b\n", 0, 8'h00, 1, make_reply(ST_BAD_POS, 0, 0, 0)});
        dir_rows.push_back('{"J1:2:3\n", 0, 8'h00, 1, make_reply(ST_BAD_POS, 0, 0, 0)});
        dir_rows.push_back('{"J7:5\n", 0, 8'h00, 1, make_reply(ST_ID_RANGE, 0, 0, 0)});
        dir_rows.push_back('{"J99999:5\n", 0, 8'h00, 1, make_reply(ST_ID_RANGE, 0, 0, 0)});
        dir_rows.push_back('{"J1\n", 0, 8'h00, 1, make_reply(ST_FORMAT, 0, 0, 0)});
        dir_rows.push_back('{"J1:\n", 0, 8'h00, 1, make_reply(ST_FORMAT, 0, 0, 0)});
        dir_rows.push_back('{"RX\n", 0, 8'h00, 1, make_reply(ST_FORMAT, 0, 0, 0)});
        dir_rows.push_back('{"R R\n", 0, 8'h00, 1, make_reply(ST_FORMAT, 0, 0, 0)});
        dir_rows.push_back('{"\013R \011\n", 0, 8'h00, 1, make_reply(ST_RESET, 0, 0, 0)});
        dir_rows.push_back('{"J:5\n", 0, 8'h00, 0, '0});
        dir_rows.push_back('{"G200:1001\n", 0, 8'h00, 0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines; a head byte goes out before the text where set.
        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            if (row.has_head)
                send_char(row.head, row.typed, row.want);
            for (int k = 0; k < row.text.len(); k++)
                send_char(row.text[k], row.typed, row.want);
        end
        drain();

        // Random phases, each with its own id map.
        for (int ph = 0; ph < 6; ph++)
        begin
            fill = (ph == 0) ? MAP_LOW : (ph == 1) ? MAP_HIGH : MAP_RANDOM;
            program_servo_map(fill);
            idle_on = (ph != 5);
            phase_chars = 0;
            while (phase_chars < PHASE_CHARS)
            begin
                gen_line();
                if (ph != 5 && $urandom_range(0, 14) == 0)
                    idle_on = !idle_on;
                foreach (line_buf[k])
                    send_char(line_buf[k], 1'b0, '0);
                phase_chars += line_buf.size();
            end
            drain();
        end

        $display("Sent %0d characters over %0d id maps; %0d replies checked, %0d mismatches.",
                 chars_sent, map_settings + 1, replies_seen, mismatches);
        $display("Replies by status 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 status_hits[0], status_hits[1], status_hits[2], status_hits[3],
                 status_hits[4], status_hits[5], status_hits[6], status_hits[7]);
        if (mismatches == 0)
            $display("servo_line_command_parser regression: pass");
        else
            $display("servo_line_command_parser regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/slcp_pkg.sv
rtl/core/slcp_line_state.sv
rtl/core/slcp_decode.sv
rtl/core/servo_line_command_parser.sv
rtl/core/slcp_checker.sv
tb/tb.sv
